// ===== design/datediff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datediff_pkg: shared types, constants and calendar tables
// Beat structs for both channels, stage advance struct, month tables.
// ----------------------------------------------------------------------------
package datediff_pkg;

	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MON_W    = 4;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned DNUM_W   = 23;
	localparam int unsigned DIFF_W   = 23;
	localparam int unsigned WIDE_W   = 25;
	localparam int unsigned MDAY_W   = 9;
	localparam int unsigned CORR_W   = YEAR_W - 2;
	localparam int unsigned QUO_W    = 8;
	localparam int unsigned REM_W    = 7;
	localparam int unsigned PROD_W   = 27;
	// floor(y / 100) = (y * RECIP100) >> RECIP_SH, exact for 14-bit y
	localparam int unsigned RECIP100 = 5243;
	localparam int unsigned RECIP_SH = 19;

	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 25'sd4194303;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -25'sd4194303;

	typedef struct packed {
		logic [DAY_W-1:0]  first_day;
		logic [MON_W-1:0]  first_month;
		logic [YEAR_W-1:0] first_year;
		logic [DAY_W-1:0]  second_day;
		logic [MON_W-1:0]  second_month;
		logic [YEAR_W-1:0] second_year;
		logic              include_end_day;
	} datediff_req_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] day_difference;
		logic                     date_invalid;
	} datediff_rsp_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} datediff_adv_t;

	// days in month, February as a common year; zero for a bad month
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1:    r = 5'd31;
			4'd2:    r = 5'd28;
			4'd3:    r = 5'd31;
			4'd4:    r = 5'd30;
			4'd5:    r = 5'd31;
			4'd6:    r = 5'd30;
			4'd7:    r = 5'd31;
			4'd8:    r = 5'd31;
			4'd9:    r = 5'd30;
			4'd10:   r = 5'd31;
			4'd11:   r = 5'd30;
			4'd12:   r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// days in the months before m, common year
	function automatic logic [MDAY_W-1:0] cum_days(input logic [MON_W-1:0] m);
		logic [MDAY_W-1:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/datediff_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datediff_lane: date to day number
// Three stages: multiplies, leap year and validity, final sum.
// Day 1 is 1 January of year 1.
// ----------------------------------------------------------------------------
module datediff_lane #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                                clk,
	input  datediff_pkg::datediff_adv_t         adv,
	input  logic [datediff_pkg::DAY_W-1:0]      day,
	input  logic [datediff_pkg::MON_W-1:0]      month,
	input  logic [datediff_pkg::YEAR_W-1:0]     year,
	output logic [datediff_pkg::DNUM_W-1:0]     dnum,
	output logic                                ok
);
	import datediff_pkg::*;

	logic [YEAR_W-1:0] p_in;
	logic [DNUM_W-1:0] p365;
	logic [PROD_W-1:0] prod;

	logic [DAY_W-1:0]  day_s1;
	logic [MON_W-1:0]  month_s1;
	logic [YEAR_W-1:0] year_s1;
	logic [DNUM_W-1:0] p365_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [YEAR_W-1:0] p_1;
	logic [QUO_W-1:0]  quo;
	logic [YEAR_W-1:0] rem_full;
	logic [REM_W-1:0]  rem;
	logic              leap;
	logic [DAY_W-1:0]  dim;
	logic              ok_c;
	logic [QUO_W-1:0]  c100;
	logic [CORR_W-1:0] corr;
	logic [MDAY_W-1:0] mday;

	logic [DNUM_W-1:0] p365_s2;
	logic [CORR_W-1:0] corr_s2;
	logic [MDAY_W-1:0] mday_s2;
	logic              ok_s2;

	logic [DNUM_W-1:0] dnum_s3;
	logic              ok_s3;

	assign p_in = year - YEAR_W'(1);
	assign p365 = DNUM_W'(p_in) * DNUM_W'(365);
	assign prod = PROD_W'(year) * PROD_W'(RECIP100);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			p365_s1  <= p365;
			prod_s1  <= prod;
		end
	end

	always_comb begin
		p_1      = year_s1 - YEAR_W'(1);
		quo      = prod_s1[RECIP_SH +: QUO_W];
		rem_full = year_s1 - YEAR_W'(quo) * YEAR_W'(100);
		rem      = rem_full[REM_W-1:0];
		leap     = ((year_s1[1:0] == 2'b00) && (rem != '0)) ||
		           ((rem == '0) && (quo[1:0] == 2'b00));
		dim      = month_len(month_s1) + DAY_W'(month_s1 == MON_FEB && leap);
		ok_c     = (year_s1 != '0) && ((YEAR_W+1)'(year_s1) <= (YEAR_W+1)'(MAX_YEAR)) &&
		           (month_s1 >= MON_JAN) && (month_s1 <= MON_DEC) &&
		           (day_s1 != '0) && (day_s1 <= dim);
		// floor((y-1)/100) from floor(y/100)
		c100     = quo - QUO_W'(rem == '0);
		corr     = CORR_W'(p_1 >> 2) - CORR_W'(c100) + CORR_W'(c100 >> 2);
		mday     = cum_days(month_s1) + MDAY_W'(leap && (month_s1 > MON_FEB)) +
		           MDAY_W'(day_s1);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p365_s2 <= p365_s1;
			corr_s2 <= corr;
			mday_s2 <= mday;
			ok_s2   <= ok_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			dnum_s3 <= p365_s2 + DNUM_W'(corr_s2) + DNUM_W'(mday_s2);
			ok_s3   <= ok_s2;
		end
	end

	assign dnum = dnum_s3;
	assign ok   = ok_s3;

endmodule

// ===== design/datediff_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datediff_merge: combine lane day numbers
// Subtract, apply end-day inclusion, saturate, zero on invalid date.
// Holds the output register.
// ----------------------------------------------------------------------------
module datediff_merge (
	input  logic                             clk,
	input  logic                             en,
	input  logic [datediff_pkg::DNUM_W-1:0]  dnum_a,
	input  logic [datediff_pkg::DNUM_W-1:0]  dnum_b,
	input  logic                             ok_a,
	input  logic                             ok_b,
	input  logic                             inc,
	output datediff_pkg::datediff_rsp_t      rsp
);
	import datediff_pkg::*;

	logic signed [WIDE_W-1:0] a_x;
	logic signed [WIDE_W-1:0] b_x;
	logic signed [WIDE_W-1:0] wide;
	logic signed [WIDE_W-1:0] adj;
	logic signed [WIDE_W-1:0] sat;
	datediff_rsp_t            rsp_c;
	datediff_rsp_t            rsp_s4;

	always_comb begin
		a_x  = {{(WIDE_W-DNUM_W){1'b0}}, dnum_a};
		b_x  = {{(WIDE_W-DNUM_W){1'b0}}, dnum_b};
		wide = b_x - a_x;
		if (!inc) begin
			adj = wide;
		end else if (wide < 0) begin
			adj = wide - 25'sd1;
		end else begin
			adj = wide + 25'sd1;
		end
		if (adj > SAT_HI) begin
			sat = SAT_HI;
		end else if (adj < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = adj;
		end
		rsp_c.date_invalid   = !(ok_a && ok_b);
		rsp_c.day_difference = (ok_a && ok_b) ? sat[DIFF_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s4 <= rsp_c;
		end
	end

	assign rsp = rsp_s4;

endmodule

// ===== design/date_difference_in_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_difference_in_days: signed Gregorian day count between two dates
//
//   channel | valid      | stall      | beat
//   --------+------------+------------+---------------------------------
//   input   | date_valid | date_stall | date : datediff_req_t (two dates)
//   output  | diff_valid | diff_stall | diff : datediff_rsp_t
//
// One beat per cycle in and out while diff_stall is low. A beat passes three lane
// stages (multiply, leap/validity, sum) and then the merge output register.
// Each stage holds only while the next one is full and held, so empty stages
// keep taking beats while a result waits at the output.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module date_difference_in_days #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         date_valid,
	output logic                         date_stall,
	input  datediff_pkg::datediff_req_t  date,
	output logic                         diff_valid,
	input  logic                         diff_stall,
	output datediff_pkg::datediff_rsp_t  diff
);
	import datediff_pkg::*;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic          inc_s1, inc_s2, inc_s3;
	logic          en4;
	datediff_adv_t adv;

	logic [DNUM_W-1:0] dnum_a, dnum_b;
	logic              ok_a, ok_b;

	assign en4    = !vld_s4 || !diff_stall;
	assign adv.s3 = !vld_s3 || en4;
	assign adv.s2 = !vld_s2 || adv.s3;
	assign adv.s1 = !vld_s1 || adv.s2;

	assign date_stall = !adv.s1;
	assign diff_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= date_valid;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
			if (en4)    vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) inc_s1 <= date.include_end_day;
		if (adv.s2) inc_s2 <= inc_s1;
		if (adv.s3) inc_s3 <= inc_s2;
	end

	datediff_lane #(
		.MAX_YEAR(MAX_YEAR)
	) u_lane_a (
		.clk   (clk),
		.adv   (adv),
		.day   (date.first_day),
		.month (date.first_month),
		.year  (date.first_year),
		.dnum  (dnum_a),
		.ok    (ok_a)
	);

	datediff_lane #(
		.MAX_YEAR(MAX_YEAR)
	) u_lane_b (
		.clk   (clk),
		.adv   (adv),
		.day   (date.second_day),
		.month (date.second_month),
		.year  (date.second_year),
		.dnum  (dnum_b),
		.ok    (ok_b)
	);

	datediff_merge u_merge (
		.clk    (clk),
		.en     (en4),
		.dnum_a (dnum_a),
		.dnum_b (dnum_b),
		.ok_a   (ok_a),
		.ok_b   (ok_b),
		.inc    (inc_s3),
		.rsp    (diff)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid && diff.date_invalid |-> diff.day_difference == '0)
		else $error("invalid date with nonzero difference");

	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid |-> diff.day_difference != 23'h400000)
		else $error("difference outside saturation range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		date_stall |-> vld_s1 && vld_s2 && vld_s3 && vld_s4)
		else $error("input stalled with an empty stage");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid && !date_stall |=> vld_s1)
		else $error("accepted beat missing from first stage");

endmodule
